// ===== hw/rtl/ibq_pkg.sv =====
// ============================================================================
// ibq_pkg
// Shared types and constants for the inverse ball query center assignment.
// ============================================================================
`default_nettype none
package ibq_pkg;

   localparam int FUNC_W   = 2;
   localparam int SLOT_W   = 8;
   localparam int BSLOT_W  = 5;
   localparam int PID_W    = 16;
   localparam int COORD_W  = 16;
   localparam int CIDX_W   = 3;
   localparam int ACEN_W   = 8;
   localparam int SRC_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_ID    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_BALL  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_COORD = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_QUERY      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BALL_SIZE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COPIES       = 2'd2;

   localparam logic [SRC_W-1:0] SRC_CENTER  = 2'd0;
   localparam logic [SRC_W-1:0] SRC_BALL    = 2'd1;
   localparam logic [SRC_W-1:0] SRC_NEAREST = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [SLOT_W-1:0]  center_slot;
      logic [BSLOT_W-1:0] ball_slot;
      logic [PID_W-1:0]   point_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [CIDX_W-1:0] copy_index;
      logic [ACEN_W-1:0] assigned_center;
      logic [SRC_W-1:0]  source;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ID_RD, ST_ID_CHK, ST_BALL_RD, ST_BALL_CHK,
      ST_DIST_RD, ST_DIST_SQ, ST_DIST_SUM, ST_DIST_ADD, ST_DIST_CMP, ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ibq_if.sv =====
// ============================================================================
// ibq_if
// Valid/ready channel carrying one payload beat.
// ============================================================================
`default_nettype none
interface ibq_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ibq_front.sv =====
// ============================================================================
// ibq_front
// Accepts beats into a two-entry queue to the back end.
// ============================================================================
`default_nettype none
module ibq_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire ibq_pkg::req_type    in_data,
   output logic                     q_valid,
   input  wire logic                q_pop,
   output ibq_pkg::req_type         q_data
);
   ibq_pkg::req_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (q_pop && q_valid) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/ibq_back.sv =====
// ============================================================================
// ibq_back
// Executes loads into the stores and runs the three query scans.
// ============================================================================
`default_nettype none
module ibq_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_pop,
   input  wire ibq_pkg::req_type  q_data,
   input  wire logic [8:0]        center_count,
   input  wire logic [5:0]        ball_size,
   input  wire logic [3:0]        copies,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output ibq_pkg::rsp_type       out_data
);
   localparam int NC = 256;
   localparam int BD = 32;
   localparam int CW = ibq_pkg::COORD_W;

   logic [ibq_pkg::PID_W-1:0] id_mem   [NC];
   logic [ibq_pkg::PID_W-1:0] ball_mem [NC*BD];
   logic [3*CW-1:0]           crd_mem  [NC];
   logic [ibq_pkg::PID_W-1:0] id_rd_ff, ball_rd_ff;
   logic [3*CW-1:0]           crd_rd_ff;

   ibq_pkg::state_type st_ff, st_in;
   ibq_pkg::req_type   cur_ff, cur_in;
   logic [8:0] m_ff, m_in;
   logic [5:0] k_ff, k_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [3:0] j_ff, j_in;
   logic [2:0] rr_ff, rr_in;
   logic [7:0] found_ff [8];
   logic       fwe;
   logic [7:0] fval;
   logic [1:0] src_ff, src_in;
   logic [8:0] n;
   logic [5:0] kz;
   logic [3:0] cp;
   logic [CW:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic [2*CW+1:0] sx_ff, sy_ff, sz_ff;
   logic [2*CW+3:0] d_ff, best_ff, best_in;
   logic [7:0] bidx_ff, bidx_in;
   logic [7:0] rd_idx;
   logic [12:0] ball_addr;

   assign n  = (center_count == 9'd0) ? 9'd1 : (center_count > 9'd256 ? 9'd256 : center_count);
   assign kz = (ball_size > 6'd32) ? 6'd32 : ball_size;
   assign cp = (copies == 4'd0) ? 4'd1 : (copies > 4'd8 ? 4'd8 : copies);
   assign rd_idx    = m_ff[7:0];
   assign ball_addr = {rd_idx, k_ff[4:0]};

   // loads write stores straight from the queue head
   always_ff @(posedge clock) begin
      if (q_pop && q_data.func == ibq_pkg::FUNC_LOAD_ID)
         id_mem[q_data.center_slot] <= q_data.point_index;
      if (q_pop && q_data.func == ibq_pkg::FUNC_LOAD_BALL)
         ball_mem[{q_data.center_slot, q_data.ball_slot}] <= q_data.point_index;
      if (q_pop && q_data.func == ibq_pkg::FUNC_LOAD_COORD)
         crd_mem[q_data.center_slot] <= {q_data.coord_x, q_data.coord_y, q_data.coord_z};
      id_rd_ff   <= id_mem[rd_idx];
      ball_rd_ff <= ball_mem[ball_addr];
      crd_rd_ff  <= crd_mem[rd_idx];
      if (fwe) found_ff[cnt_ff[2:0]] <= fval;
   end

   function automatic logic [CW:0] adiff(input logic signed [CW-1:0] a,
                                         input logic signed [CW-1:0] b);
      logic signed [CW:0] d;
      begin
         d = {a[CW-1], a} - {b[CW-1], b};
         adiff = d[CW] ? -d : d;
      end
   endfunction

   always_comb begin
      st_in = st_ff; cur_in = cur_ff; m_in = m_ff; k_in = k_ff;
      cnt_in = cnt_ff; j_in = j_ff; rr_in = rr_ff; src_in = src_ff;
      best_in = best_ff; bidx_in = bidx_ff;
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff;
      q_pop = 1'b0; fwe = 1'b0; fval = rd_idx;
      out_valid = 1'b0;
      out_data.copy_index      = j_ff[2:0];
      out_data.assigned_center = found_ff[rr_ff];
      out_data.source          = src_ff;
      out_data.last            = (j_ff + 4'd1 == cp);
      case (st_ff)
         ibq_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_data.func == ibq_pkg::FUNC_QUERY) begin
                  cur_in = q_data; m_in = 9'd0; cnt_in = 4'd0;
                  st_in = ibq_pkg::ST_ID_RD;
               end
            end
         end
         ibq_pkg::ST_ID_RD: st_in = ibq_pkg::ST_ID_CHK;
         ibq_pkg::ST_ID_CHK: begin
            if (id_rd_ff == cur_ff.point_index) begin
               fwe = 1'b1; cnt_in = 4'd1; src_in = ibq_pkg::SRC_CENTER;
               j_in = 4'd0; rr_in = 3'd0; st_in = ibq_pkg::ST_EMIT;
            end else if (m_ff + 9'd1 < n) begin
               m_in = m_ff + 9'd1; st_in = ibq_pkg::ST_ID_RD;
            end else begin
               m_in = 9'd0; k_in = 6'd0; src_in = ibq_pkg::SRC_BALL;
               st_in = (kz == 6'd0) ? ibq_pkg::ST_DIST_RD : ibq_pkg::ST_BALL_RD;
            end
         end
         ibq_pkg::ST_BALL_RD: st_in = ibq_pkg::ST_BALL_CHK;
         ibq_pkg::ST_BALL_CHK: begin
            if (ball_rd_ff == cur_ff.point_index) begin
               fwe = 1'b1; cnt_in = cnt_ff + 4'd1;
               if (cnt_ff + 4'd1 == cp || m_ff + 9'd1 == n) begin
                  j_in = 4'd0; rr_in = 3'd0; st_in = ibq_pkg::ST_EMIT;
               end else begin
                  m_in = m_ff + 9'd1; k_in = 6'd0; st_in = ibq_pkg::ST_BALL_RD;
               end
            end else if (k_ff + 6'd1 < kz) begin
               k_in = k_ff + 6'd1; st_in = ibq_pkg::ST_BALL_RD;
            end else if (m_ff + 9'd1 < n) begin
               m_in = m_ff + 9'd1; k_in = 6'd0; st_in = ibq_pkg::ST_BALL_RD;
            end else if (cnt_ff != 4'd0) begin
               j_in = 4'd0; rr_in = 3'd0; st_in = ibq_pkg::ST_EMIT;
            end else begin
               m_in = 9'd0; st_in = ibq_pkg::ST_DIST_RD;
            end
         end
         ibq_pkg::ST_DIST_RD: begin
            src_in = ibq_pkg::SRC_NEAREST; st_in = ibq_pkg::ST_DIST_SQ;
         end
         ibq_pkg::ST_DIST_SQ: begin
            dx_in = adiff(cur_ff.coord_x, crd_rd_ff[3*CW-1:2*CW]);
            dy_in = adiff(cur_ff.coord_y, crd_rd_ff[2*CW-1:CW]);
            dz_in = adiff(cur_ff.coord_z, crd_rd_ff[CW-1:0]);
            st_in = ibq_pkg::ST_DIST_SUM;
         end
         // squares land at the end of SUM, their sum at the end of ADD
         ibq_pkg::ST_DIST_SUM: st_in = ibq_pkg::ST_DIST_ADD;
         ibq_pkg::ST_DIST_ADD: st_in = ibq_pkg::ST_DIST_CMP;
         ibq_pkg::ST_DIST_CMP: begin
            if (m_ff == 9'd0 || d_ff < best_ff) begin
               best_in = d_ff; bidx_in = rd_idx;
            end
            if (m_ff + 9'd1 < n) begin
               m_in = m_ff + 9'd1; st_in = ibq_pkg::ST_DIST_RD;
            end else begin
               fwe = 1'b1;
               fval = (m_ff == 9'd0 || d_ff < best_ff) ? rd_idx : bidx_ff;
               cnt_in = 4'd1; j_in = 4'd0; rr_in = 3'd0;
               st_in = ibq_pkg::ST_EMIT;
            end
         end
         ibq_pkg::ST_EMIT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               j_in = j_ff + 4'd1;
               rr_in = (rr_ff + 3'd1 == cnt_ff[2:0] || {1'b0, rr_ff} + 4'd1 == cnt_ff)
                       ? 3'd0 : rr_ff + 3'd1;
               if (j_ff + 4'd1 == cp) st_in = ibq_pkg::ST_IDLE;
            end
         end
         default: st_in = ibq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ibq_pkg::ST_IDLE;
      else       st_ff <= st_in;
      cur_ff <= cur_in; m_ff <= m_in; k_ff <= k_in; cnt_ff <= cnt_in;
      j_ff <= j_in; rr_ff <= rr_in; src_ff <= src_in;
      best_ff <= best_in; bidx_ff <= bidx_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
      sx_ff <= dx_ff * dx_ff; sy_ff <= dy_ff * dy_ff; sz_ff <= dz_ff * dz_ff;
      d_ff <= {2'b00, sx_ff} + {2'b00, sy_ff} + {2'b00, sz_ff};
   end
endmodule
`default_nettype wire

// ===== hw/rtl/inverse_ball_query_center_assign.sv =====
// ============================================================================
// inverse_ball_query_center_assign
// Assigns each query point a run of centers: own center, else ball hits, else nearest.
// ============================================================================
// channel | dir | payload
// req     | in  | func, center_slot, ball_slot, point_index, coord_x/y/z
// rsp     | out | copy_index, assigned_center, source, last
// csr     | in  | write enable, index, data
// A load is queued and is written to its store when the back end pops it. A query
// is popped, then scans ids (ID_RD, ID_CHK per center), balls (BALL_RD, BALL_CHK
// per entry), then distances (DIST_RD, SQ, SUM, ADD, CMP per center); the store
// read ports are registered, which sets these steps.
// Reset is synchronous; a two-beat queue lets req accept while rsp stalls.
`default_nettype none
module inverse_ball_query_center_assign (
   input  wire logic clock,
   input  wire logic reset,
   ibq_if.sink       req,
   ibq_if.source     rsp,
   input  wire logic                            csr_we,
   input  wire logic [ibq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ibq_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   logic [8:0] center_count_ff;
   logic [5:0] ball_size_ff;
   logic [3:0] copies_ff;
   logic q_valid, q_pop;
   ibq_pkg::req_type q_data;
   ibq_pkg::rsp_type rsp_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_count_ff <= 9'd256; ball_size_ff <= 6'd32; copies_ff <= 4'd8;
      end else if (csr_we) begin
         case (csr_index)
            ibq_pkg::CSR_CENTER_COUNT: center_count_ff <= csr_wdata;
            ibq_pkg::CSR_BALL_SIZE:    ball_size_ff    <= csr_wdata[5:0];
            ibq_pkg::CSR_COPIES:       copies_ff       <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   ibq_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .q_valid, .q_pop, .q_data
   );

   ibq_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .center_count(center_count_ff), .ball_size(ball_size_ff), .copies(copies_ff),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp_d)
   );
   assign rsp.data = rsp_d;
endmodule
`default_nettype wire
